### src/ccz_glt_pkg.sv
// ----------------------------------------------------------------------------
// ccz_glt_pkg
// Shared types, constants and helpers of the graph linear transform block.
// ----------------------------------------------------------------------------
package ccz_glt_pkg;

   // S-box width limits
   localparam int IN_MAX  = 8;
   localparam int OUT_MAX = 8;

   // field widths of the channels
   localparam int WIDTH_REG_W = 4;
   localparam int COL_IDX_W   = 4;
   localparam int COL_W       = 16;
   localparam int POINT_W     = 8;
   localparam int RD_IDX_W    = 8;
   localparam int VALUE_W     = 8;

   localparam int COL_COUNT = 1 << COL_IDX_W;

   // table geometry
   localparam int TBL_AW    = IN_MAX;
   localparam int TBL_DEPTH = 1 << TBL_AW;

   // configuration register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_BITS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_BITS = CSR_IDX_W'(1);

   localparam logic [WIDTH_REG_W-1:0] IN_MAX_CODE  = WIDTH_REG_W'(IN_MAX);
   localparam logic [WIDTH_REG_W-1:0] OUT_MAX_CODE = WIDTH_REG_W'(OUT_MAX);
   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = WIDTH_REG_W'(8);

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_LOAD_COL = 2'd1,
      OP_INSERT   = 2'd2,
      OP_READ     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD
   } state_type;

   // column write into the map
   typedef struct packed {
      logic                 load;
      logic [COL_IDX_W-1:0] index;
      logic [COL_W-1:0]     value;
   } col_load_type;

   // command into the table
   typedef struct packed {
      logic               clear;
      logic               insert;
      logic               read;
      logic [TBL_AW-1:0]  addr;
      logic [OUT_MAX-1:0] data;
   } tbl_cmd_type;

   // status out of the table
   typedef struct packed {
      logic [OUT_MAX-1:0] value;
      logic               valid;
      logic               collision;
   } tbl_rsp_type;

   // zero acts as one, above the limit acts as the limit
   function automatic logic [WIDTH_REG_W-1:0] clamp_width(
      input logic [WIDTH_REG_W-1:0] w,
      input logic [WIDTH_REG_W-1:0] maxw
   );
      logic [WIDTH_REG_W-1:0] r;
      r = w;
      if (w == '0) begin
         r = WIDTH_REG_W'(1);
      end else if (w > maxw) begin
         r = maxw;
      end
      return r;
   endfunction

endpackage

### src/ccz_glt_if.sv
// ----------------------------------------------------------------------------
// ccz_glt_req_if / ccz_glt_rsp_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface ccz_glt_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          op;
   logic [ccz_glt_pkg::COL_IDX_W-1:0]   column_index;
   logic [ccz_glt_pkg::COL_W-1:0]       column_value;
   logic [ccz_glt_pkg::POINT_W-1:0]     point_x;
   logic [ccz_glt_pkg::POINT_W-1:0]     point_y;
   logic [ccz_glt_pkg::RD_IDX_W-1:0]    read_index;

   modport source (
      output valid, op, column_index, column_value, point_x, point_y, read_index,
      input  ready
   );
   modport sink (
      input  valid, op, column_index, column_value, point_x, point_y, read_index,
      output ready
   );
endinterface

interface ccz_glt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ccz_glt_pkg::VALUE_W-1:0]   entry_value;
   logic                              entry_valid;
   logic                              collision;

   modport source (
      output valid, entry_value, entry_valid, collision,
      input  ready
   );
   modport sink (
      input  valid, entry_value, entry_valid, collision,
      output ready
   );
endinterface

### src/ccz_graph_linear_transform.sv
// ----------------------------------------------------------------------------
// ccz_graph_linear_transform
// Maps graph points of an S-box through a GF(2) linear map into a new table.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request word: op selects clear, load map column,
//   insert point or read entry. rsp_bus returns exactly one response word
//   per request: entry value and valid for a read (zero otherwise) and the
//   collision flag as it stands after the request.
//   csr_we/csr_index/csr_wdata set in_bits and out_bits (reset 8 each);
//   write them only while no request is in flight.
// Timing:
//   A request is accepted only in IDLE, passes EXEC and then LOAD, and its
//   response is registered on leaving LOAD; the next word is accepted only
//   back in IDLE. The order is set by the execute step plus the registered
//   read of the value memory, which finishes before the next word enters.
// Reset:
//   Synchronous, active high: map columns, fill marks and collision clear;
//   the value memory keeps garbage, read only behind a fill mark.
// Stall:
//   A response held by a low rsp_bus.ready does not block intake: the next
//   word is accepted and executed, then waits until the output frees.
// ----------------------------------------------------------------------------
module ccz_graph_linear_transform (
   input  logic                                   clock,
   input  logic                                   reset,
   ccz_glt_req_if.sink                            req_bus,
   ccz_glt_rsp_if.source                          rsp_bus,
   input  logic                                   csr_we,
   input  logic [ccz_glt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccz_glt_pkg::WIDTH_REG_W-1:0]    csr_wdata
);

   // configuration
   logic [ccz_glt_pkg::WIDTH_REG_W-1:0] in_bits_ff;
   logic [ccz_glt_pkg::WIDTH_REG_W-1:0] out_bits_ff;
   logic [ccz_glt_pkg::WIDTH_REG_W-1:0] m_eff;
   logic [ccz_glt_pkg::WIDTH_REG_W-1:0] n_eff;

   // sequencer
   ccz_glt_pkg::state_type state_ff;
   ccz_glt_pkg::state_type state_in;
   logic                   accept;
   logic                   rsp_load;

   // captured request word
   ccz_glt_pkg::op_type                  op_ff;
   logic [ccz_glt_pkg::COL_IDX_W-1:0]    col_idx_ff;
   logic [ccz_glt_pkg::COL_W-1:0]        col_val_ff;
   logic [ccz_glt_pkg::POINT_W-1:0]      x_ff;
   logic [ccz_glt_pkg::POINT_W-1:0]      y_ff;
   logic [ccz_glt_pkg::RD_IDX_W-1:0]     rd_idx_ff;

   // datapath links
   ccz_glt_pkg::col_load_type            col_load;
   ccz_glt_pkg::tbl_cmd_type             tbl_cmd;
   ccz_glt_pkg::tbl_rsp_type             tbl_rsp;
   logic [ccz_glt_pkg::TBL_AW-1:0]       new_x;
   logic [ccz_glt_pkg::OUT_MAX-1:0]      new_y;

   // response register
   logic                                 rsp_valid_ff;
   logic [ccz_glt_pkg::VALUE_W-1:0]      rsp_value_ff;
   logic                                 rsp_entry_valid_ff;
   logic                                 rsp_collision_ff;

   // ---- configuration registers --------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_bits_ff  <= ccz_glt_pkg::WIDTH_RESET;
         out_bits_ff <= ccz_glt_pkg::WIDTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ccz_glt_pkg::CSR_IN_BITS:  in_bits_ff  <= csr_wdata;
            ccz_glt_pkg::CSR_OUT_BITS: out_bits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // out-of-range widths fold onto the nearest legal value
   assign m_eff = ccz_glt_pkg::clamp_width(in_bits_ff, ccz_glt_pkg::IN_MAX_CODE);
   assign n_eff = ccz_glt_pkg::clamp_width(out_bits_ff, ccz_glt_pkg::OUT_MAX_CODE);

   // ---- request capture -----------------------------------------------------
   assign accept = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= ccz_glt_pkg::op_type'(req_bus.op);
         col_idx_ff <= req_bus.column_index;
         col_val_ff <= req_bus.column_value;
         x_ff       <= req_bus.point_x;
         y_ff       <= req_bus.point_y;
         rd_idx_ff  <= req_bus.read_index;
      end
   end

   // ---- sequencer: next state ------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccz_glt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ccz_glt_pkg::ST_EXEC;
            end
         end
         ccz_glt_pkg::ST_EXEC: begin
            state_in = ccz_glt_pkg::ST_LOAD;
         end
         ccz_glt_pkg::ST_LOAD: begin
            if (rsp_load) begin
               state_in = ccz_glt_pkg::ST_IDLE;
            end
         end
         default: state_in = ccz_glt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccz_glt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---- sequencer: outputs ---------------------------------------------------
   // EXEC issues the map write or the table command; the table registers its
   // read data for LOAD, which moves it into the response register.
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_load      = 1'b0;
      col_load      = '0;
      tbl_cmd       = '0;
      unique case (state_ff)
         ccz_glt_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ccz_glt_pkg::ST_EXEC: begin
            unique case (op_ff)
               ccz_glt_pkg::OP_CLEAR: begin
                  tbl_cmd.clear = 1'b1;
               end
               ccz_glt_pkg::OP_LOAD_COL: begin
                  col_load.load  = 1'b1;
                  col_load.index = col_idx_ff;
                  col_load.value = col_val_ff;
               end
               ccz_glt_pkg::OP_INSERT: begin
                  tbl_cmd.insert = 1'b1;
                  tbl_cmd.addr   = new_x;
                  tbl_cmd.data   = new_y;
               end
               ccz_glt_pkg::OP_READ: begin
                  tbl_cmd.read = 1'b1;
                  tbl_cmd.addr = ccz_glt_pkg::TBL_AW'(rd_idx_ff);
               end
               default: ;
            endcase
         end
         ccz_glt_pkg::ST_LOAD: begin
            rsp_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: ;
      endcase
   end

   // ---- datapath --------------------------------------------------------------
   ccz_glt_map u_map (
      .clock    (clock),
      .reset    (reset),
      .col_load (col_load),
      .point_x  (x_ff),
      .point_y  (y_ff),
      .m_eff    (m_eff),
      .n_eff    (n_eff),
      .new_x    (new_x),
      .new_y    (new_y)
   );

   ccz_glt_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .rsp   (tbl_rsp)
   );

   // ---- response register -------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // entry fields only count for a read; drop them for every other op
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (op_ff == ccz_glt_pkg::OP_READ) begin
            rsp_value_ff       <= ccz_glt_pkg::VALUE_W'(tbl_rsp.value);
            rsp_entry_valid_ff <= tbl_rsp.valid;
         end else begin
            rsp_value_ff       <= '0;
            rsp_entry_valid_ff <= 1'b0;
         end
         rsp_collision_ff <= tbl_rsp.collision;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.entry_value = rsp_value_ff;
   assign rsp_bus.entry_valid = rsp_entry_valid_ff;
   assign rsp_bus.collision   = rsp_collision_ff;

   // ---- checks ---------------------------------------------------------------------
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ccz_glt_pkg::ST_EXEC))
      else $error("accepted word did not enter execute");

   a_load_only: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ccz_glt_pkg::ST_LOAD))
      else $error("response raised outside the load step");

   a_non_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && op_ff != ccz_glt_pkg::OP_READ)
         |=> (rsp_value_ff == '0 && !rsp_entry_valid_ff))
      else $error("entry fields set for an op other than read");

endmodule

### src/ccz_glt_map.sv
// ----------------------------------------------------------------------------
// ccz_glt_map
// Column register file of the GF(2) map and the product of a packed point.
// ----------------------------------------------------------------------------
module ccz_glt_map (
   input  logic                                     clock,
   input  logic                                     reset,
   input  ccz_glt_pkg::col_load_type                col_load,
   input  logic [ccz_glt_pkg::POINT_W-1:0]          point_x,
   input  logic [ccz_glt_pkg::POINT_W-1:0]          point_y,
   input  logic [ccz_glt_pkg::WIDTH_REG_W-1:0]      m_eff,
   input  logic [ccz_glt_pkg::WIDTH_REG_W-1:0]      n_eff,
   output logic [ccz_glt_pkg::TBL_AW-1:0]           new_x,
   output logic [ccz_glt_pkg::OUT_MAX-1:0]          new_y
);

   logic [ccz_glt_pkg::COL_W-1:0]     cols_ff [ccz_glt_pkg::COL_COUNT];
   logic [ccz_glt_pkg::IN_MAX-1:0]    mask_m;
   logic [ccz_glt_pkg::OUT_MAX-1:0]   mask_n;
   logic [ccz_glt_pkg::COL_W-1:0]     word;
   logic [ccz_glt_pkg::COL_W-1:0]     prod;
   logic [ccz_glt_pkg::COL_COUNT-1:0] plane [ccz_glt_pkg::COL_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ccz_glt_pkg::COL_COUNT; k++) begin
            cols_ff[k] <= '0;
         end
      end else if (col_load.load) begin
         cols_ff[col_load.index] <= col_load.value;
      end
   end

   // low-bit masks of the active widths
   always_comb begin
      for (int i = 0; i < ccz_glt_pkg::IN_MAX; i++) begin
         mask_m[i] = (ccz_glt_pkg::WIDTH_REG_W'(i) < m_eff);
      end
      for (int i = 0; i < ccz_glt_pkg::OUT_MAX; i++) begin
         mask_n[i] = (ccz_glt_pkg::WIDTH_REG_W'(i) < n_eff);
      end
   end

   // pack (x << n) | y, bits beyond the column count drop
   assign word = (ccz_glt_pkg::COL_W'(ccz_glt_pkg::IN_MAX'(point_x) & mask_m) << n_eff)
               | ccz_glt_pkg::COL_W'(ccz_glt_pkg::OUT_MAX'(point_y) & mask_n);

   // each product bit is the parity of the selected column bits
   always_comb begin
      for (int b = 0; b < ccz_glt_pkg::COL_W; b++) begin
         for (int k = 0; k < ccz_glt_pkg::COL_COUNT; k++) begin
            plane[b][k] = word[k] & cols_ff[k][b];
         end
         prod[b] = ^plane[b];
      end
   end

   assign new_x = ccz_glt_pkg::TBL_AW'(prod >> n_eff) & ccz_glt_pkg::TBL_AW'(mask_m);
   assign new_y = ccz_glt_pkg::OUT_MAX'(prod) & mask_n;

endmodule

### src/ccz_glt_table.sv
// ----------------------------------------------------------------------------
// ccz_glt_table
// Value memory of the new S-box with fill marks and the sticky collision flag.
// ----------------------------------------------------------------------------
module ccz_glt_table (
   input  logic                      clock,
   input  logic                      reset,
   input  ccz_glt_pkg::tbl_cmd_type  cmd,
   output ccz_glt_pkg::tbl_rsp_type  rsp
);

   logic [ccz_glt_pkg::OUT_MAX-1:0]   value_mem_ff [ccz_glt_pkg::TBL_DEPTH];
   logic [ccz_glt_pkg::TBL_DEPTH-1:0] marks_ff;
   logic [ccz_glt_pkg::TBL_DEPTH-1:0] marks_in;
   logic                              collision_ff;
   logic                              collision_in;
   logic [ccz_glt_pkg::OUT_MAX-1:0]   rd_data_ff;
   logic                              rd_mark_ff;
   logic                              wr_en;

   // first write to a slot wins, later ones only raise the flag
   assign wr_en = cmd.insert && !cmd.clear && !marks_ff[cmd.addr];

   always_comb begin
      marks_in     = marks_ff;
      collision_in = collision_ff;
      priority if (cmd.clear) begin
         marks_in     = '0;
         collision_in = 1'b0;
      end else if (cmd.insert) begin
         if (marks_ff[cmd.addr]) begin
            collision_in = 1'b1;
         end else begin
            marks_in[cmd.addr] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff     <= '0;
         collision_ff <= 1'b0;
      end else begin
         marks_ff     <= marks_in;
         collision_ff <= collision_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem_ff[cmd.addr] <= cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= value_mem_ff[cmd.addr];
         rd_mark_ff <= marks_ff[cmd.addr];
      end
   end

   assign rsp.value     = rd_mark_ff ? rd_data_ff : '0;
   assign rsp.valid     = rd_mark_ff;
   assign rsp.collision = collision_ff;

   a_collision_sets: assert property (@(posedge clock) disable iff (reset)
      (cmd.insert && !cmd.clear && marks_ff[cmd.addr]) |=> collision_ff)
      else $error("insert into a filled slot did not raise collision");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (marks_ff == '0 && !collision_ff))
      else $error("clear left marks or collision set");

endmodule

### dv/ccz_graph_linear_transform_tb.sv
// ----------------------------------------------------------------------------
// ccz_graph_linear_transform_tb
// Self-checking bench for the graph linear transform: request words go in
// from a planned queue and each response is checked against a local
// predictor. The predictor holds its own map, table, fill marks and
// collision flag. Widths change between phases while the block is idle.
// ----------------------------------------------------------------------------
module ccz_graph_linear_transform_tb;

   localparam int SETTLE_CYCLES = 4;     // idle margin after the last response
   localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
   localparam int WORD_TARGET   = 1825;  // directed plus random request words
   localparam int REPORT_CAP    = 100;

   typedef enum logic [1:0] {
      ACT_WORD,
      ACT_DRAIN,
      ACT_CSR
   } action_type;

   typedef struct {
      action_type                          kind;
      ccz_glt_pkg::op_type                 op;
      logic [ccz_glt_pkg::COL_IDX_W-1:0]   column_index;
      logic [ccz_glt_pkg::COL_W-1:0]       column_value;
      logic [ccz_glt_pkg::POINT_W-1:0]     point_x;
      logic [ccz_glt_pkg::POINT_W-1:0]     point_y;
      logic [ccz_glt_pkg::RD_IDX_W-1:0]    read_index;
      logic [ccz_glt_pkg::CSR_IDX_W-1:0]   csr_idx;
      logic [ccz_glt_pkg::WIDTH_REG_W-1:0] csr_val;
   } plan_type;

   typedef struct packed {
      logic [ccz_glt_pkg::VALUE_W-1:0] value;
      logic                            valid;
      logic                            collision;
   } result_type;

   typedef struct {
      result_type  result;
      int unsigned stamp;   // cycle of acceptance
   } pending_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [ccz_glt_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [ccz_glt_pkg::WIDTH_REG_W-1:0] csr_wdata;

   ccz_glt_req_if req_bus ();
   ccz_glt_rsp_if rsp_bus ();

   ccz_graph_linear_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Predictor state: a private copy of everything the block remembers.
   logic [ccz_glt_pkg::COL_W-1:0]       map_col [ccz_glt_pkg::COL_COUNT];
   logic [ccz_glt_pkg::VALUE_W-1:0]     slot_value [ccz_glt_pkg::TBL_DEPTH];
   logic                                slot_filled [ccz_glt_pkg::TBL_DEPTH];
   logic                                flag_collision;
   logic [ccz_glt_pkg::WIDTH_REG_W-1:0] reg_in_bits;
   logic [ccz_glt_pkg::WIDTH_REG_W-1:0] reg_out_bits;

   plan_type    plan_q [$];
   pending_type outstanding [$];
   plan_type    cur_word;

   int unsigned cycle_count = 0;
   int          stall_cycles = 0;
   int          settle_count = 0;
   int          mismatches = 0;
   int          words_planned = 0;
   int          words_sent = 0;
   int          results_seen = 0;
   int          settings_planned = 0;
   int          valid_reads = 0;
   int          collisions_predicted = 0;

   // Hold both sides free of random idling for a long stretch in mid-run.
   logic calm;
   assign calm = (words_sent >= 600) && (words_sent < 950);

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Zero widens to one, anything above the limit acts as the limit.
   function automatic int effective_width(
      input logic [ccz_glt_pkg::WIDTH_REG_W-1:0] raw,
      input int limit);
      if (raw == '0) return 1;
      if (int'(raw) > limit) return limit;
      return int'(raw);
   endfunction

   // Apply one accepted request word to the predictor and return the response
   // the block owes for it.
   function automatic result_type transform_word(input plan_type w);
      result_type  r;
      int          m;
      int          n;
      logic [31:0] mask_m;
      logic [31:0] mask_n;
      logic [31:0] graph_word;
      logic [31:0] image;
      logic [7:0]  slot;
      m = effective_width(reg_in_bits, ccz_glt_pkg::IN_MAX);
      n = effective_width(reg_out_bits, ccz_glt_pkg::OUT_MAX);
      mask_m = (32'd1 << m) - 32'd1;
      mask_n = (32'd1 << n) - 32'd1;
      r = '0;
      case (w.op)
         ccz_glt_pkg::OP_CLEAR: begin
            // marks and flag only; the map survives
            foreach (slot_filled[i]) slot_filled[i] = 1'b0;
            flag_collision = 1'b0;
         end
         ccz_glt_pkg::OP_LOAD_COL: begin
            map_col[w.column_index] = w.column_value;
         end
         ccz_glt_pkg::OP_INSERT: begin
            // pack (x, y), then XOR the columns of every set bit
            graph_word = ((32'(w.point_x) & mask_m) << n) | (32'(w.point_y) & mask_n);
            image = '0;
            for (int k = 0; k < m + n; k++) begin
               if (graph_word[k]) image = image ^ 32'(map_col[k]);
            end
            image = image & ((32'd1 << (m + n)) - 32'd1);
            slot = 8'((image >> n) & mask_m);
            if (slot_filled[slot]) begin
               // occupied slot keeps its first value
               flag_collision = 1'b1;
               collisions_predicted++;
            end else begin
               slot_value[slot]  = 8'(image & mask_n);
               slot_filled[slot] = 1'b1;
            end
         end
         default: begin
            if (slot_filled[w.read_index]) begin
               r.value = slot_value[w.read_index];
               r.valid = 1'b1;
               valid_reads++;
            end
         end
      endcase
      r.collision = flag_collision;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("mismatch at cycle %0d: %s expected %0h got %0h",
                  cycle_count, what, want, got);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus planning
   // -------------------------------------------------------------------------

   task automatic push_word(input ccz_glt_pkg::op_type op,
                            input logic [ccz_glt_pkg::COL_IDX_W-1:0] ci,
                            input logic [ccz_glt_pkg::COL_W-1:0] cv,
                            input logic [ccz_glt_pkg::POINT_W-1:0] px,
                            input logic [ccz_glt_pkg::POINT_W-1:0] py,
                            input logic [ccz_glt_pkg::RD_IDX_W-1:0] ri);
      plan_type e;
      e.kind         = ACT_WORD;
      e.op           = op;
      e.column_index = ci;
      e.column_value = cv;
      e.point_x      = px;
      e.point_y      = py;
      e.read_index   = ri;
      e.csr_idx      = '0;
      e.csr_val      = '0;
      plan_q.insert(plan_q.size(), e);
      words_planned++;
   endtask

   // Unused fields get random bits; the block must ignore them.
   task automatic push_load(input int idx, input logic [ccz_glt_pkg::COL_W-1:0] val);
      push_word(ccz_glt_pkg::OP_LOAD_COL, ccz_glt_pkg::COL_IDX_W'(idx), val,
                8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic push_insert(input logic [7:0] px, input logic [7:0] py);
      push_word(ccz_glt_pkg::OP_INSERT, 4'($urandom), 16'($urandom), px, py,
                8'($urandom));
   endtask

   task automatic push_read(input logic [7:0] ri);
      push_word(ccz_glt_pkg::OP_READ, 4'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), ri);
   endtask

   task automatic push_clear();
      push_word(ccz_glt_pkg::OP_CLEAR, 4'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
   endtask

   task automatic push_drain();
      plan_type e;
      e = '{kind: ACT_DRAIN, op: ccz_glt_pkg::OP_CLEAR, default: '0};
      plan_q.insert(plan_q.size(), e);
   endtask

   // Drain first: widths change only while nothing is in flight.
   task automatic push_widths(input logic [ccz_glt_pkg::WIDTH_REG_W-1:0] raw_in,
                              input logic [ccz_glt_pkg::WIDTH_REG_W-1:0] raw_out);
      plan_type e;
      push_drain();
      e = '{kind: ACT_CSR, op: ccz_glt_pkg::OP_CLEAR, default: '0};
      e.csr_idx = ccz_glt_pkg::CSR_IN_BITS;
      e.csr_val = raw_in;
      plan_q.insert(plan_q.size(), e);
      e.csr_idx = ccz_glt_pkg::CSR_OUT_BITS;
      e.csr_val = raw_out;
      plan_q.insert(plan_q.size(), e);
      settings_planned++;
   endtask

   function automatic logic [ccz_glt_pkg::WIDTH_REG_W-1:0] pick_width_code();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return '0;
      if (pick < 14) return ccz_glt_pkg::WIDTH_REG_W'($urandom_range(15, 9));
      return ccz_glt_pkg::WIDTH_REG_W'($urandom_range(8, 1));
   endfunction

   // One phase: set widths, load a map, clear, insert the whole graph of a
   // random S-box, read back, then some noise. A graph-keeping map is upper
   // block triangular, so the new inputs stay a bijection and never collide.
   task automatic plan_phase(input bit first);
      logic [ccz_glt_pkg::WIDTH_REG_W-1:0] raw_in;
      logic [ccz_glt_pkg::WIDTH_REG_W-1:0] raw_out;
      int          m;
      int          n;
      int          total;
      int          span;
      int          pick;
      int          other;
      logic [31:0] mask_n;
      logic [31:0] mask_total;
      logic [7:0]  mask_m8;
      logic [7:0]  mask_n8;
      logic [7:0]  tmp;
      logic [15:0] col;
      logic [15:0] a_cols [8];
      logic [15:0] b_cols [8];
      logic [7:0]  order [256];
      bit          keep_graph;
      if (first) begin
         raw_in  = ccz_glt_pkg::WIDTH_REG_W'(8);
         raw_out = ccz_glt_pkg::WIDTH_REG_W'(8);
      end else begin
         raw_in  = pick_width_code();
         raw_out = pick_width_code();
      end
      push_widths(raw_in, raw_out);
      m          = effective_width(raw_in, ccz_glt_pkg::IN_MAX);
      n          = effective_width(raw_out, ccz_glt_pkg::OUT_MAX);
      total      = m + n;
      span       = 1 << m;
      mask_n     = (32'd1 << n) - 32'd1;
      mask_total = (32'd1 << total) - 32'd1;
      mask_m8    = 8'((32'd1 << m) - 32'd1);
      mask_n8    = 8'(mask_n);
      keep_graph = first || ($urandom_range(1) == 0);

      // random invertible blocks by elementary column operations
      for (int i = 0; i < 8; i++) begin
         a_cols[i] = 16'(1 << i);
         b_cols[i] = 16'(1 << i);
      end
      repeat (3 * m) begin
         pick  = $urandom_range(m - 1);
         other = $urandom_range(m - 1);
         if (pick != other) a_cols[pick] = a_cols[pick] ^ a_cols[other];
      end
      repeat (3 * n) begin
         pick  = $urandom_range(n - 1);
         other = $urandom_range(n - 1);
         if (pick != other) b_cols[pick] = b_cols[pick] ^ b_cols[other];
      end

      for (int k = 0; k < total; k++) begin
         if (!keep_graph) col = 16'(32'($urandom) & mask_total);
         else if (k < n) col = b_cols[k];
         else col = (a_cols[k - n] << n) | 16'(32'($urandom) & mask_n);
         // bits above the product width must be dropped
         if (total < 16 && $urandom_range(3) == 0)
            col = col | 16'(32'($urandom) & ~mask_total);
         push_load(k, col);
      end
      if ($urandom_range(3) == 0) begin
         for (int k = total; k < ccz_glt_pkg::COL_COUNT; k++) push_load(k, 16'($urandom));
      end
      push_clear();

      for (int i = 0; i < span; i++) order[i] = 8'(i);
      for (int i = span - 1; i > 0; i--) begin
         pick        = $urandom_range(i);
         tmp         = order[i];
         order[i]    = order[pick];
         order[pick] = tmp;
      end
      for (int i = 0; i < span; i++) begin
         push_insert(order[i] | (($urandom_range(3) == 0) ? (8'($urandom) & ~mask_m8) : 8'h00),
                     8'($urandom));
      end
      if (!first && $urandom_range(2) == 0) push_insert(8'($urandom), 8'($urandom) & mask_n8);
      // hold the sender until every response is back
      if ($urandom_range(3) == 0) push_drain();

      for (int i = 0; i < span / 2 + 4; i++) begin
         if ($urandom_range(9) < 3) push_read(8'($urandom));
         else push_read(8'($urandom_range(span - 1)));
      end
      if (!first) begin
         repeat ($urandom_range(5))
            push_word(ccz_glt_pkg::op_type'($urandom_range(3)), 4'($urandom),
                      16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // Directed opening at the reset widths (8, 8), then the width extremes.
   // Reads only touch slots already written.
   task automatic plan_directed();
      push_load(0, 16'h0001);
      push_load(8, 16'h0100);
      push_load(7, 16'h8000);
      push_load(15, 16'hFFFF);
      push_insert(8'h00, 8'h00);
      push_insert(8'hFF, 8'hFF);      // all columns: lands on slot 7E
      push_insert(8'h00, 8'h01);      // same slot as the first point
      push_read(8'h00);
      push_read(8'h7E);
      push_clear();
      push_read(8'h7E);               // written, no longer marked
      push_insert(8'h01, 8'h80);
      push_read(8'h81);
      // acts as 1 and 8
      push_widths(ccz_glt_pkg::WIDTH_REG_W'(0), ccz_glt_pkg::WIDTH_REG_W'(15));
      push_insert(8'hFE, 8'hAA);      // upper x bits masked off
      push_insert(8'hFF, 8'h00);
      push_read(8'h81);               // beyond the table of a one-bit S-box
      push_read(8'h7E);
      // acts as 8 and 1
      push_widths(ccz_glt_pkg::WIDTH_REG_W'(15), ccz_glt_pkg::WIDTH_REG_W'(0));
      push_insert(8'h80, 8'hFF);      // upper y bits masked off
      push_read(8'h80);
      push_clear();
      push_read(8'h01);
   endtask

   // -------------------------------------------------------------------------
   // Driver: present planned words, apply register writes while idle
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      plan_type                            head;
      pending_type                         pend;
      logic                                drive_valid;
      logic                                do_csr;
      logic [ccz_glt_pkg::CSR_IDX_W-1:0]   next_idx;
      logic [ccz_glt_pkg::WIDTH_REG_W-1:0] next_val;
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.op           <= '0;
         req_bus.column_index <= '0;
         req_bus.column_value <= '0;
         req_bus.point_x      <= '0;
         req_bus.point_y      <= '0;
         req_bus.read_index   <= '0;
         csr_we               <= 1'b0;
         csr_index            <= '0;
         csr_wdata            <= '0;
         settle_count         = 0;
         // predictor starts from the reset state of the block
         reg_in_bits          = ccz_glt_pkg::WIDTH_RESET;
         reg_out_bits         = ccz_glt_pkg::WIDTH_RESET;
         flag_collision       = 1'b0;
         foreach (map_col[i]) map_col[i] = '0;
         foreach (slot_value[i]) slot_value[i] = '0;
         foreach (slot_filled[i]) slot_filled[i] = 1'b0;
         cur_word = '{kind: ACT_WORD, op: ccz_glt_pkg::OP_CLEAR, default: '0};
      end else begin
         drive_valid = req_bus.valid;
         do_csr      = 1'b0;
         next_idx    = csr_index;
         next_val    = csr_wdata;
         // predict at the accepting edge, stamped so the monitor ignores it
         // until the next edge
         if (req_bus.valid && req_bus.ready) begin
            pend.result = transform_word(cur_word);
            pend.stamp  = cycle_count;
            outstanding.insert(outstanding.size(), pend);
            words_sent++;
            drive_valid = 1'b0;
         end
         if (!drive_valid && plan_q.size() > 0) begin
            head = plan_q[0];
            case (head.kind)
               ACT_WORD: begin
                  if (calm || $urandom_range(99) >= 21) begin
                     cur_word    = plan_q.pop_front();
                     drive_valid = 1'b1;
                  end
               end
               ACT_DRAIN: begin
                  // wait out every response, then let the pipeline settle
                  if (outstanding.size() != 0) begin
                     settle_count = 0;
                  end else if (settle_count >= SETTLE_CYCLES) begin
                     void'(plan_q.pop_front());
                     settle_count = 0;
                  end else begin
                     settle_count++;
                  end
               end
               default: begin
                  void'(plan_q.pop_front());
                  do_csr   = 1'b1;
                  next_idx = head.csr_idx;
                  next_val = head.csr_val;
                  if (head.csr_idx == ccz_glt_pkg::CSR_IN_BITS) reg_in_bits = head.csr_val;
                  else reg_out_bits = head.csr_val;
               end
            endcase
         end
         req_bus.valid        <= drive_valid;
         req_bus.op           <= cur_word.op;
         req_bus.column_index <= cur_word.column_index;
         req_bus.column_value <= cur_word.column_value;
         req_bus.point_x      <= cur_word.point_x;
         req_bus.point_y      <= cur_word.point_y;
         req_bus.read_index   <= cur_word.read_index;
         csr_we               <= do_csr;
         csr_index            <= next_idx;
         csr_wdata            <= next_val;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: check each response word against the oldest prediction
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      result_type  want;
      pending_type pend;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (outstanding.size() == 0 || outstanding[0].stamp == cycle_count) begin
               report_mismatch("response with no request outstanding", 0, 0);
            end else begin
               pend = outstanding.pop_front();
               want = pend.result;
               if (rsp_bus.entry_value !== want.value)
                  report_mismatch("entry_value", int'(want.value),
                                  int'(rsp_bus.entry_value));
               if (rsp_bus.entry_valid !== want.valid)
                  report_mismatch("entry_valid", int'(want.valid),
                                  int'(rsp_bus.entry_valid));
               if (rsp_bus.collision !== want.collision)
                  report_mismatch("collision", int'(want.collision),
                                  int'(rsp_bus.collision));
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= 21);
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d responses pending",
                  stall_cycles, outstanding.size());
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence: plan everything, reset, run until every word is answered
   // -------------------------------------------------------------------------
   initial begin : run_test
      reset = 1'b1;

      plan_directed();
      // the first phase fills every slot, so later reads never hit an
      // unwritten entry
      plan_phase(1'b1);
      while (words_planned < WORD_TARGET) plan_phase(1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (plan_q.size() != 0 || words_sent != words_planned || outstanding.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      $display("covered %0d request words and %0d responses over %0d width settings",
               words_sent, results_seen, settings_planned);
      $display("table reads that hit a filled slot: %0d, collisions: %0d",
               valid_reads, collisions_predicted);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
src/ccz_glt_pkg.sv
src/ccz_glt_if.sv
src/ccz_glt_map.sv
src/ccz_glt_table.sv
src/ccz_graph_linear_transform.sv
dv/ccz_graph_linear_transform_tb.sv
